>>> src/mmga_pkg.sv
// Shared constants and widths for the multi-mode gather address generator.
package mmga_pkg;

    // Default table depths.
    localparam int IDX_DEPTH_DEFAULT = 1024;
    localparam int OFF_DEPTH_DEFAULT = 1024;

    // Data and arithmetic widths.
    localparam int DATA_W = 32;
    localparam int FLAT_W = 27;
    localparam int SUM_W = 52;
    localparam int PIPE_LATENCY = 5;

    // Request operations.
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_WR_INDEX = 2'd1;
    localparam logic [1:0] OP_WR_OFFSET = 2'd2;

    // Mapping modes.
    localparam logic [2:0] MODE_INVALID = 3'd0;
    localparam logic [2:0] MODE_SINGLE = 3'd1;
    localparam logic [2:0] MODE_BLOCKS = 3'd2;
    localparam logic [2:0] MODE_SHIFTED = 3'd3;
    localparam logic [2:0] MODE_STRIDE = 3'd4;
    localparam logic [2:0] MODE_STENCIL = 3'd5;
    localparam logic [2:0] MODE_TABLE = 3'd6;
    localparam logic [2:0] MODE_RESERVED = 3'd7;

    // Result status codes.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_COORD = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_OUTSIDE = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAP_MODE = 3'd0;
    localparam logic [2:0] CFG_REP_COUNT = 3'd1;
    localparam logic [2:0] CFG_GROUP_SIZE = 3'd2;
    localparam logic [2:0] CFG_BASE_OFFSET = 3'd3;
    localparam logic [2:0] CFG_REP_STEP = 3'd4;
    localparam logic [2:0] CFG_COMP_STEP = 3'd5;
    localparam logic [2:0] CFG_REP_SHIFT = 3'd6;
    localparam logic [2:0] CFG_SRC_LENGTH = 3'd7;

endpackage

>>> src/mmga_ram.sv
// Simple dual-port table memory with one write port and a registered read port.
module mmga_ram
    import mmga_pkg::*;
#(
    parameter int DEPTH = IDX_DEPTH_DEFAULT,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/multi_mode_gather_address_generator_core.sv
// A query passes the stage 1, stage 2, stage 3, stage 4 and output registers before its result shows on the ports.
// Throughput: one request per cycle; busy stays low since the pipeline never stalls.
// Table writes take effect for every query accepted after them and produce no result.
// Reset (rst_n low, asynchronous) restores the configuration defaults and empties the pipeline.
// The index and offset tables are not cleared by reset.
module multi_mode_gather_address_generator_core
    import mmga_pkg::*;
#(
    parameter int INDEX_DEPTH = IDX_DEPTH_DEFAULT,
    parameter int OFFSET_DEPTH = OFF_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [15:0]        rep_number,
    input  logic [9:0]         component_number,
    input  logic [9:0]         table_addr,
    input  logic signed [31:0] table_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               result_valid,
    output logic signed [31:0] source_index,
    output logic [2:0]         status
);

    localparam int IAW = $clog2(INDEX_DEPTH);
    localparam int OAW = $clog2(OFFSET_DEPTH);
    localparam logic [FLAT_W-1:0] IDX_LIMIT = FLAT_W'(INDEX_DEPTH);
    localparam logic [FLAT_W-1:0] OFF_LIMIT = FLAT_W'(OFFSET_DEPTH);

    // Configuration registers.
    logic [2:0]         map_mode_reg;
    logic [15:0]        rep_count_reg;
    logic [10:0]        group_size_reg;
    logic signed [31:0] base_offset_reg;
    logic signed [31:0] rep_step_reg;
    logic signed [31:0] comp_step_reg;
    logic signed [31:0] rep_shift_reg;
    logic [30:0]        src_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg    <= MODE_INVALID;
            rep_count_reg   <= 16'd1;
            group_size_reg  <= '0;
            base_offset_reg <= '0;
            rep_step_reg    <= '0;
            comp_step_reg   <= 32'sd1;
            rep_shift_reg   <= '0;
            src_length_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAP_MODE:    map_mode_reg    <= cfg_data[2:0];
                CFG_REP_COUNT:   rep_count_reg   <= cfg_data[15:0];
                CFG_GROUP_SIZE:  group_size_reg  <= cfg_data[10:0];
                CFG_BASE_OFFSET: base_offset_reg <= cfg_data;
                CFG_REP_STEP:    rep_step_reg    <= cfg_data;
                CFG_COMP_STEP:   comp_step_reg   <= cfg_data;
                CFG_REP_SHIFT:   rep_shift_reg   <= cfg_data;
                CFG_SRC_LENGTH:  src_length_reg  <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    // The pipeline accepts a request in every cycle.
    assign busy = 1'b0;

    // Stage 1: captured request.
    logic               s1_valid_reg;
    logic [1:0]         s1_op_reg;
    logic [15:0]        s1_rep_reg;
    logic [9:0]         s1_comp_reg;
    logic [9:0]         s1_addr_reg;
    logic signed [31:0] s1_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= operation;
        s1_rep_reg  <= rep_number;
        s1_comp_reg <= component_number;
        s1_addr_reg <= table_addr;
        s1_data_reg <= table_data;
    end

    // Stage 1 logic: descriptor and coordinate checks, flat address, shifted repetition.
    logic                s1_query;
    logic [FLAT_W-1:0]   s1_flat;
    logic [FLAT_W-1:0]   s1_capacity;
    logic [FLAT_W-1:0]   s1_comp_wide;
    logic [FLAT_W-1:0]   s1_addr_wide;
    logic [FLAT_W-1:0]   s1_group_wide;
    logic [FLAT_W-1:0]   s1_idx_rd_wide;
    logic signed [32:0]  s1_shift;
    logic signed [32:0]  s2_srep_next;
    logic [2:0]          s2_status_next;
    logic                idx_we;
    logic                off_we;

    assign s1_query      = s1_valid_reg && (s1_op_reg == OP_QUERY);
    assign s1_comp_wide  = FLAT_W'(s1_comp_reg);
    assign s1_addr_wide  = FLAT_W'(s1_addr_reg);
    assign s1_group_wide = FLAT_W'(group_size_reg);
    assign s1_flat       = FLAT_W'(s1_rep_reg) * s1_group_wide + s1_comp_wide;
    assign s1_capacity   = FLAT_W'(rep_count_reg) * s1_group_wide;
    assign s1_shift      = (map_mode_reg == MODE_SHIFTED) ? 33'(rep_shift_reg) : '0;
    assign s2_srep_next  = $signed({17'd0, s1_rep_reg}) + s1_shift;
    assign s1_idx_rd_wide = (map_mode_reg == MODE_SINGLE) ? s1_comp_wide : s1_flat;

    // Early status in check order; a clean item may still overflow or fall outside later.
    always_comb
    begin
        priority if (map_mode_reg == MODE_INVALID || map_mode_reg == MODE_RESERVED
                     || rep_count_reg == '0
                     || (map_mode_reg == MODE_SINGLE && rep_count_reg != 16'd1))
        begin
            s2_status_next = ST_INVALID;
        end
        else if (s1_rep_reg >= rep_count_reg || s1_comp_wide >= s1_group_wide)
        begin
            s2_status_next = ST_COORD;
        end
        else if ((map_mode_reg == MODE_SINGLE && s1_group_wide > IDX_LIMIT)
                 || (map_mode_reg == MODE_TABLE && s1_capacity > IDX_LIMIT)
                 || (map_mode_reg == MODE_STENCIL && s1_group_wide > OFF_LIMIT))
        begin
            s2_status_next = ST_INVALID;
        end
        else if (map_mode_reg == MODE_SHIFTED && s2_srep_next[32] != s2_srep_next[31])
        begin
            s2_status_next = ST_OVERFLOW;
        end
        else
        begin
            s2_status_next = ST_OK;
        end
    end

    // Table writes and reads happen in request order at the end of stage 1.
    assign idx_we = s1_valid_reg && (s1_op_reg == OP_WR_INDEX) && (s1_addr_wide < IDX_LIMIT);
    assign off_we = s1_valid_reg && (s1_op_reg == OP_WR_OFFSET) && (s1_addr_wide < OFF_LIMIT);

    logic [DATA_W-1:0] idx_rdata;
    logic [DATA_W-1:0] off_rdata;

    mmga_ram #(
        .DEPTH (INDEX_DEPTH)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (s1_addr_wide[IAW-1:0]),
        .wdata (s1_data_reg),
        .raddr (s1_idx_rd_wide[IAW-1:0]),
        .rdata (idx_rdata)
    );

    mmga_ram #(
        .DEPTH (OFFSET_DEPTH)
    ) u_offset_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (s1_addr_wide[OAW-1:0]),
        .wdata (s1_data_reg),
        .raddr (s1_comp_wide[OAW-1:0]),
        .rdata (off_rdata)
    );

    // Stage 2: operands for the multipliers.
    logic               s2_valid_reg;
    logic [15:0]        s2_rep_reg;
    logic [9:0]         s2_comp_reg;
    logic signed [32:0] s2_srep_reg;
    logic [2:0]         s2_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_query;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_rep_reg    <= s1_rep_reg;
        s2_comp_reg   <= s1_comp_reg;
        s2_srep_reg   <= s2_srep_next;
        s2_status_reg <= s2_status_next;
    end

    // Stage 2 logic: three products in parallel.
    logic signed [48:0] s3_prep_next;
    logic signed [44:0] s3_pgrp_next;
    logic signed [42:0] s3_pcomp_next;

    assign s3_prep_next  = $signed({1'b0, s2_rep_reg}) * rep_step_reg;
    assign s3_pgrp_next  = s2_srep_reg * $signed({1'b0, group_size_reg});
    assign s3_pcomp_next = $signed({1'b0, s2_comp_reg}) * comp_step_reg;

    // Stage 3: products and table data.
    logic               s3_valid_reg;
    logic [9:0]         s3_comp_reg;
    logic [2:0]         s3_status_reg;
    logic signed [48:0] s3_prep_reg;
    logic signed [44:0] s3_pgrp_reg;
    logic signed [42:0] s3_pcomp_reg;
    logic signed [31:0] s3_idx_reg;
    logic signed [31:0] s3_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_comp_reg   <= s2_comp_reg;
        s3_status_reg <= s2_status_reg;
        s3_prep_reg   <= s3_prep_next;
        s3_pgrp_reg   <= s3_pgrp_next;
        s3_pcomp_reg  <= s3_pcomp_next;
        s3_idx_reg    <= idx_rdata;
        s3_off_reg    <= off_rdata;
    end

    // Stage 3 logic: exact index sum for the configured mode.
    logic signed [SUM_W-1:0] s4_sum_next;

    always_comb
    begin
        unique case (map_mode_reg)
            MODE_BLOCKS, MODE_SHIFTED:
                s4_sum_next = SUM_W'(s3_pgrp_reg) + SUM_W'(s3_comp_reg);
            MODE_STRIDE:
                s4_sum_next = SUM_W'(base_offset_reg) + SUM_W'(s3_prep_reg)
                              + SUM_W'(s3_pcomp_reg);
            MODE_STENCIL:
                s4_sum_next = SUM_W'(base_offset_reg) + SUM_W'(s3_prep_reg)
                              + SUM_W'(s3_off_reg);
            MODE_SINGLE, MODE_TABLE:
                s4_sum_next = SUM_W'(s3_idx_reg);
            default:
                s4_sum_next = '0;
        endcase
    end

    // Stage 4: sum awaiting the range checks.
    logic                    s4_valid_reg;
    logic [2:0]              s4_status_reg;
    logic signed [SUM_W-1:0] s4_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_status_reg <= s3_status_reg;
        s4_sum_reg    <= s4_sum_next;
    end

    // Stage 4 logic: overflow and source range checks.
    logic                 s4_fits;
    logic [2:0]           out_status_next;
    logic signed [31:0]   out_index_next;

    assign s4_fits = (s4_sum_reg[SUM_W-1:31] == '0) || (s4_sum_reg[SUM_W-1:31] == '1);

    always_comb
    begin
        out_index_next = '0;
        priority if (s4_status_reg != ST_OK)
        begin
            out_status_next = s4_status_reg;
        end
        else if (!s4_fits)
        begin
            out_status_next = ST_OVERFLOW;
        end
        else if (s4_sum_reg[31] || s4_sum_reg[30:0] >= src_length_reg)
        begin
            out_status_next = ST_OUTSIDE;
        end
        else
        begin
            out_status_next = ST_OK;
            out_index_next  = s4_sum_reg[31:0];
        end
    end

    // Output registers: each result shows for exactly one cycle.
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic signed [31:0] out_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign source_index = out_index_reg;

endmodule

>>> src/mmga_checker.sv
// Port-level checks for the gather address generator and their bind to the top level.
module mmga_checker
    import mmga_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         operation,
    input logic [15:0]        rep_number,
    input logic [9:0]         component_number,
    input logic [9:0]         table_addr,
    input logic signed [31:0] table_data,
    input logic               cfg_we,
    input logic [2:0]         cfg_index,
    input logic [31:0]        cfg_data,
    input logic               result_valid,
    input logic signed [31:0] source_index,
    input logic [2:0]         status
);

    logic query_acc;

    assign query_acc = rst_n && start && !busy && (operation == OP_QUERY);

    // Every query, and nothing else, yields a result.
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (result_valid == $past(query_acc, PIPE_LATENCY)))
    else $error("result strobe does not match an accepted query");

    // A failed query reports index zero.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_OK) |-> (source_index == '0))
    else $error("nonzero index with an error status");

    // A successful index is never negative.
    a_ok_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_OK) |-> !source_index[31])
    else $error("negative index with ok status");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status <= ST_OUTSIDE))
    else $error("undefined status code");

endmodule

bind multi_mode_gather_address_generator_core mmga_checker u_mmga_checker (.*);

>>> test/tb_multi_mode_gather_address_generator_core.sv
// Self-checking testbench for the multi-mode gather address generator core.
module tb_multi_mode_gather_address_generator_core
    import mmga_pkg::*;
();

    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam int IDX_DEPTH = IDX_DEPTH_DEFAULT;
    localparam int OFF_DEPTH = OFF_DEPTH_DEFAULT;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One request as the driver presents it.
    typedef struct {
        logic [1:0]         op;
        logic [15:0]        rep;
        logic [9:0]         comp;
        logic [9:0]         addr;
        logic signed [31:0] data;
    } gather_req_t;

    // One expected query answer.
    typedef struct {
        logic signed [31:0] src_index;
        logic [2:0]         code;
    } gather_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         operation = OP_QUERY;
    logic [15:0]        rep_number = '0;
    logic [9:0]         component_number = '0;
    logic [9:0]         table_addr = '0;
    logic signed [31:0] table_data = '0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = CFG_MAP_MODE;
    logic [31:0]        cfg_data = '0;
    logic               result_valid;
    logic signed [31:0] source_index;
    logic [2:0]         status;

    gather_req_t    gather_requests[$];
    gather_answer_t expected_answers[$];
    int             err_count = 0;

    // Driver pacing.
    bit req_taken = 1'b0;
    int idle_left = 0;
    int idle_pct = 0;
    bit steady = 1'b0;

    // Predictor copy of the configuration and tables.
    logic [2:0]         mdl_map_mode = MODE_INVALID;
    logic [15:0]        mdl_rep_count = 16'd1;
    logic [10:0]        mdl_group_size = '0;
    logic signed [31:0] mdl_base = '0;
    logic signed [31:0] mdl_rep_step = '0;
    logic signed [31:0] mdl_comp_step = 32'sd1;
    logic signed [31:0] mdl_rep_shift = '0;
    logic [30:0]        mdl_src_length = '0;
    logic signed [31:0] mdl_index_tbl [IDX_DEPTH];
    logic signed [31:0] mdl_offset_tbl [OFF_DEPTH];

    // Stimulus-side view of the settings and of which table entries hold data.
    logic [2:0]  plan_mode = MODE_INVALID;
    logic [15:0] plan_rc = 16'd1;
    logic [10:0] plan_gs = '0;
    bit          idx_written [IDX_DEPTH];
    bit          off_written [OFF_DEPTH];

    multi_mode_gather_address_generator_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .rep_number       (rep_number),
        .component_number (component_number),
        .table_addr       (table_addr),
        .table_data       (table_data),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .source_index     (source_index),
        .status           (status)
    );

    // Free-running clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #400000;
        $display("tb_multi_mode_gather_address_generator_core: done, errors");
        $finish;
    end

    // Print one mismatch line and count it; printing stops after 40 mismatches.
    task automatic flag_mismatch(input string what);
        err_count++;
        if (err_count <= 40)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Exact index and status for a query under the current predictor state.
    function automatic void predict_gather(input logic [15:0] rep, input logic [9:0] comp,
                                           output logic signed [31:0] idx,
                                           output logic [2:0] st);
        longint r, c, g, v, sr, flat;
        r = longint'(rep);
        c = longint'(comp);
        g = longint'(mdl_group_size);
        v = 0;
        idx = '0;
        st = ST_OK;
        if (mdl_map_mode == MODE_INVALID || mdl_map_mode > MODE_TABLE || mdl_rep_count == 0)
            st = ST_INVALID;
        else if (mdl_map_mode == MODE_SINGLE && mdl_rep_count != 16'd1)
            st = ST_INVALID;
        else if (rep >= mdl_rep_count || comp >= mdl_group_size)
            st = ST_COORD;
        else
        begin
            case (mdl_map_mode)
                MODE_SINGLE:
                begin
                    if (mdl_group_size > IDX_DEPTH)
                        st = ST_INVALID;
                    else
                        v = longint'(mdl_index_tbl[comp]);
                end
                MODE_BLOCKS:
                    v = r * g + c;
                MODE_SHIFTED:
                begin
                    // The shifted repetition must itself fit before it is scaled.
                    sr = r + longint'(mdl_rep_shift);
                    if (sr < I32_MIN || sr > I32_MAX)
                        st = ST_OVERFLOW;
                    else
                        v = sr * g + c;
                end
                MODE_STRIDE:
                    v = longint'(mdl_base) + r * longint'(mdl_rep_step)
                        + c * longint'(mdl_comp_step);
                MODE_STENCIL:
                begin
                    if (mdl_group_size > OFF_DEPTH)
                        st = ST_INVALID;
                    else
                        v = longint'(mdl_base) + r * longint'(mdl_rep_step)
                            + longint'(mdl_offset_tbl[comp]);
                end
                default:
                begin
                    flat = r * g + c;
                    if (longint'(mdl_rep_count) * g > IDX_DEPTH || flat >= IDX_DEPTH)
                        st = ST_INVALID;
                    else
                        v = longint'(mdl_index_tbl[flat[9:0]]);
                end
            endcase
        end
        if (st == ST_OK)
        begin
            if (v < I32_MIN || v > I32_MAX)
                st = ST_OVERFLOW;
            else if (v < 0 || v >= longint'(mdl_src_length))
                st = ST_OUTSIDE;
            else
                idx = v[31:0];
        end
    endfunction

    // Driver: presents queued requests at the falling edge, with random idle bursts.
    always @(negedge clk)
    begin : drive_requests
        gather_req_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || req_taken)
        begin
            req_taken = 1'b0;
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (gather_requests.size() != 0 && !steady
                     && $urandom_range(0, 99) < idle_pct)
            begin
                idle_left = $urandom_range(0, 7);
                start <= 1'b0;
            end
            else if (gather_requests.size() != 0)
            begin
                nxt = gather_requests.pop_front();
                start <= 1'b1;
                operation <= nxt.op;
                rep_number <= nxt.rep;
                component_number <= nxt.comp;
                table_addr <= nxt.addr;
                table_data <= nxt.data;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks results, tracks configuration writes and accepted requests.
    always @(posedge clk)
    begin : watch_results
        gather_answer_t want;
        logic signed [31:0] idx;
        logic [2:0] st;
        if (rst_n)
        begin
            // Compare a delivered result with the oldest expectation.
            if (result_valid)
            begin
                if (expected_answers.size() == 0)
                    flag_mismatch($sformatf("result with none expected: index %0d status %0d",
                                            source_index, status));
                else
                begin
                    want = expected_answers.pop_front();
                    if (source_index !== want.src_index)
                        flag_mismatch($sformatf("source_index %0d, expected %0d",
                                                source_index, want.src_index));
                    if (status !== want.code)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                status, want.code));
                end
            end

            // Mirror configuration writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAP_MODE:    mdl_map_mode = cfg_data[2:0];
                    CFG_REP_COUNT:   mdl_rep_count = cfg_data[15:0];
                    CFG_GROUP_SIZE:  mdl_group_size = cfg_data[10:0];
                    CFG_BASE_OFFSET: mdl_base = cfg_data;
                    CFG_REP_STEP:    mdl_rep_step = cfg_data;
                    CFG_COMP_STEP:   mdl_comp_step = cfg_data;
                    CFG_REP_SHIFT:   mdl_rep_shift = cfg_data;
                    CFG_SRC_LENGTH:  mdl_src_length = cfg_data[30:0];
                endcase
            end

            // Apply an accepted request to the predictor.
            if (start && !busy)
            begin
                req_taken = 1'b1;
                case (operation)
                    OP_QUERY:
                    begin
                        predict_gather(rep_number, component_number, idx, st);
                        want.src_index = idx;
                        want.code = st;
                        expected_answers = {expected_answers, want};
                    end
                    OP_WR_INDEX:  mdl_index_tbl[table_addr] = table_data;
                    OP_WR_OFFSET: mdl_offset_tbl[table_addr] = table_data;
                    default:      ;
                endcase
            end
        end
    end

    // Random word with a bias toward small values and the signed extremes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom();
            3:       return int'($urandom_range(0, 200000)) - 100000;
            default: return int'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    // Table entry that a query would read under the planned settings, or -1.
    function automatic int table_slot_read(input logic [15:0] rep, input logic [9:0] comp,
                                           output bit is_offset);
        is_offset = 1'b0;
        if (plan_rc == 0 || rep >= plan_rc || comp >= plan_gs)
            return -1;
        case (plan_mode)
            MODE_SINGLE:
                if (plan_rc == 16'd1 && plan_gs <= IDX_DEPTH)
                    return comp;
            MODE_STENCIL:
                if (plan_gs <= OFF_DEPTH)
                begin
                    is_offset = 1'b1;
                    return comp;
                end
            MODE_TABLE:
                if (int'(plan_rc) * int'(plan_gs) <= IDX_DEPTH)
                    return int'(rep) * int'(plan_gs) + int'(comp);
            default: ;
        endcase
        return -1;
    endfunction

    // Queue a table write; unused fields carry random values.
    task automatic push_write(input logic [1:0] op, input logic [9:0] addr,
                              input logic [31:0] data);
        gather_req_t q;
        q.op = op;
        q.rep = 16'($urandom());
        q.comp = 10'($urandom());
        q.addr = addr;
        q.data = data;
        if (op == OP_WR_INDEX)
            idx_written[addr] = 1'b1;
        else if (op == OP_WR_OFFSET)
            off_written[addr] = 1'b1;
        gather_requests = {gather_requests, q};
    endtask

    // Queue a query, loading the table entry it reads first if it holds no data yet.
    task automatic push_query(input logic [15:0] rep, input logic [9:0] comp);
        gather_req_t q;
        bit is_off;
        int slot;
        slot = table_slot_read(rep, comp, is_off);
        if (slot >= 0)
        begin
            if (is_off && !off_written[slot])
                push_write(OP_WR_OFFSET, 10'(slot), pick_word());
            else if (!is_off && !idx_written[slot])
                push_write(OP_WR_INDEX, 10'(slot), pick_word());
        end
        q.op = OP_QUERY;
        q.rep = rep;
        q.comp = comp;
        q.addr = 10'($urandom());
        q.data = $urandom();
        gather_requests = {gather_requests, q};
    endtask

    // Queue a request with the unused operation code; the block ignores it.
    task automatic push_noise();
        gather_req_t q;
        q.op = OP_UNUSED;
        q.rep = 16'($urandom());
        q.comp = 10'($urandom());
        q.addr = 10'($urandom());
        q.data = $urandom();
        gather_requests = {gather_requests, q};
    endtask

    // Wait until every request is taken and every answer has arrived, then settle.
    task automatic wait_until_idle();
        do
            @(posedge clk);
        while (gather_requests.size() != 0 || start || expected_answers.size() != 0);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    // Program all registers while the block is idle.
    task automatic apply_settings(input logic [2:0] mode, input logic [15:0] rc,
                                  input logic [10:0] gs, input logic [31:0] base,
                                  input logic [31:0] rstep, input logic [31:0] cstep,
                                  input logic [31:0] shift, input logic [30:0] len);
        write_register(CFG_MAP_MODE, {29'd0, mode});
        write_register(CFG_REP_COUNT, {16'd0, rc});
        write_register(CFG_GROUP_SIZE, {21'd0, gs});
        write_register(CFG_BASE_OFFSET, base);
        write_register(CFG_REP_STEP, rstep);
        write_register(CFG_COMP_STEP, cstep);
        write_register(CFG_REP_SHIFT, shift);
        write_register(CFG_SRC_LENGTH, {1'b0, len});
        @(negedge clk);
        cfg_we <= 1'b0;
        plan_mode = mode;
        plan_rc = rc;
        plan_gs = gs;
    endtask

    // Random settings for one mode, mostly small shapes with some extremes.
    task automatic pick_random_settings(input logic [2:0] mode);
        logic [15:0] rc;
        logic [10:0] gs;
        logic [30:0] len;
        case ($urandom_range(0, 9))
            0:       gs = 11'd1024;
            1:       gs = $urandom_range(0, 1) ? 11'd0 : 11'd1025;
            default: gs = 11'($urandom_range(1, 48));
        endcase
        case (mode)
            MODE_SINGLE:
                rc = ($urandom_range(0, 7) == 0) ? 16'd2 : 16'd1;
            MODE_TABLE:
            begin
                // Keep the flat table within capacity most of the time.
                gs = 11'($urandom_range(1, 64));
                rc = 16'(IDX_DEPTH / int'(gs));
                if ($urandom_range(0, 7) != 0)
                    rc = 16'($urandom_range(1, rc));
                else
                    rc = rc + 16'd1;
            end
            default:
                rc = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 3))
            0:       len = 31'($urandom_range(0, 200));
            1:       len = 31'h7fffffff;
            2:       len = 31'($urandom_range(0, 100000));
            default: len = 31'($urandom());
        endcase
        apply_settings(mode, rc, gs, pick_word(), pick_word(), pick_word(), pick_word(), len);
    endtask

    // Random mix of queries and table writes under the current settings.
    task automatic run_random_phase(input int n_items);
        int pick;
        logic [15:0] rep;
        logic [9:0] comp;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                push_noise();
            pick = $urandom_range(0, 99);
            if (pick < 10)
                push_write(OP_WR_INDEX, ($urandom_range(0, 3) == 0) ? 10'($urandom())
                                        : 10'($urandom_range(0, 63)), pick_word());
            else if (pick < 18)
                push_write(OP_WR_OFFSET, ($urandom_range(0, 3) == 0) ? 10'($urandom())
                                         : 10'($urandom_range(0, 63)), pick_word());
            else
            begin
                rep = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                      : 16'($urandom_range(0, plan_rc));
                comp = ($urandom_range(0, 9) == 0) ? 10'($urandom())
                       : 10'($urandom_range(0, (plan_gs > 11'd1023) ? 1023 : plan_gs));
                push_query(rep, comp);
            end
        end
        wait_until_idle();
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings describe no valid map; the unused code gives nothing.
        push_query(16'd0, 10'd0);
        push_noise();
        wait_until_idle();

        // Blocks at the largest shape.
        apply_settings(MODE_BLOCKS, 16'hffff, 11'd1024, 0, 0, 1, 0, 31'h7fffffff);
        push_query(16'd0, 10'd0);
        push_query(16'd65534, 10'd1023);
        push_query(16'd65535, 10'd0);
        wait_until_idle();

        // Single table with positive, negative and largest entries.
        apply_settings(MODE_SINGLE, 16'd1, 11'd1024, 0, 0, 1, 0, 31'd100);
        push_write(OP_WR_INDEX, 10'd0, 32'sd5);
        push_write(OP_WR_INDEX, 10'd1023, -32'sd1);
        push_write(OP_WR_INDEX, 10'd7, 32'h7fffffff);
        push_query(16'd0, 10'd0);
        push_query(16'd0, 10'd1023);
        push_query(16'd0, 10'd7);
        push_query(16'd1, 10'd0);
        wait_until_idle();

        // Single mode needs exactly one repetition.
        apply_settings(MODE_SINGLE, 16'd2, 11'd4, 0, 0, 1, 0, 31'd100);
        push_query(16'd0, 10'd0);
        wait_until_idle();

        // Stride at the top of the signed range.
        apply_settings(MODE_STRIDE, 16'd4, 11'd4, 32'h7fffffff, 32'd1, -32'sd1, 0,
                       31'h7fffffff);
        push_query(16'd0, 10'd0);
        push_query(16'd1, 10'd0);
        push_query(16'd1, 10'd1);
        push_query(16'd2, 10'd3);
        wait_until_idle();

        // Shifted repetition overflows before and after scaling.
        apply_settings(MODE_SHIFTED, 16'd4, 11'd2, 0, 0, 1, 32'h7fffffff, 31'h7fffffff);
        push_query(16'd1, 10'd0);
        push_query(16'd0, 10'd1);
        wait_until_idle();

        // Table capacity exceeded in stencil and flat table modes.
        apply_settings(MODE_STENCIL, 16'd3, 11'd1025, 0, 1, 1, 0, 31'd1000);
        push_query(16'd0, 10'd0);
        wait_until_idle();
        apply_settings(MODE_TABLE, 16'd2, 11'd600, 0, 0, 1, 0, 31'd1000);
        push_query(16'd0, 10'd0);
        wait_until_idle();

        // Unused mode code and a zero repetition count.
        apply_settings(MODE_RESERVED, 16'd4, 11'd4, 0, 0, 1, 0, 31'd1000);
        push_query(16'd0, 10'd0);
        wait_until_idle();
        apply_settings(MODE_BLOCKS, 16'd0, 11'd4, 0, 0, 1, 0, 31'd1000);
        push_query(16'd0, 10'd0);
        wait_until_idle();

        // Random phases through every mode; the last ones run without idling.
        for (int p = 0; p < 16; p++)
        begin
            steady = (p >= 14);
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 30;
                default: idle_pct = 60;
            endcase
            pick_random_settings(3'((p % 6) + 1));
            run_random_phase(100);
        end

        if (err_count == 0)
            $display("tb_multi_mode_gather_address_generator_core: done, clean");
        else
            $display("tb_multi_mode_gather_address_generator_core: done, errors");
        $finish;
    end

endmodule
